// ===== design/ucd_pkg.sv =====
// ucd_pkg: constants, beat types and controller/datapath interface structs
// for the undirected cycle detector; no dependencies
package ucd_pkg;

  localparam int MaxVertices = 256;
  localparam int MaxEdges    = 1024;
  localparam int VW = $clog2(MaxVertices);
  localparam int EW = $clog2(MaxEdges);
  localparam int CW = VW + 1;

  typedef struct packed {
    logic [7:0] edge_u;
    logic [7:0] edge_v;
    logic       edge_present;
    logic       last_edge;
  } in_beat_t;

  typedef struct packed {
    logic has_cycle;
    logic bad_edge;
  } out_beat_t;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_CLR   = 8'b0000_0010,
    S_ROOT  = 8'b0000_0100,
    S_FETCH = 8'b0000_1000,
    S_EVAL  = 8'b0001_0000,
    S_POP   = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_WAIT  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic root;
    logic fetch;
    logic eval;
    logic pop;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic root_skip;
    logic root_end;
    logic scan_end;
    logic found;
    logic stack_empty;
  } stat_t;

endpackage

// ===== design/ucd_datapath.sv =====
// ucd_datapath: edge store, visited map, walk stack and scan logic
// depends on ucd_pkg
module ucd_datapath (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [8:0]      cfg_data,
  input  ucd_pkg::in_beat_t in_beat,
  input  ucd_pkg::cmd_t   cmd,
  output ucd_pkg::stat_t  stat,
  output ucd_pkg::out_beat_t res
);
  import ucd_pkg::*;

  logic [8:0]  vcount;
  logic [EW:0] etotal;
  logic        bad;
  logic [MaxVertices-1:0] visited;
  logic [2*VW-1:0] estore [MaxEdges];
  logic [2*VW-1:0] erd;
  logic [VW-1:0] sv   [MaxVertices];
  logic [EW-1:0] ste  [MaxVertices];
  logic          stt  [MaxVertices];
  logic [EW:0]   sscn [MaxVertices];
  logic [CW-1:0] sp;
  logic [VW-1:0] t_v;
  logic [EW-1:0] t_e;
  logic          t_t;
  logic [EW:0]   t_s;
  logic [CW-1:0] root;
  logic          found;
  logic [CW-1:0] nact;
  logic          in_ok;
  logic [VW-1:0] other;
  logic          hit;
  logic [EW-1:0] scan_e;

  assign nact  = (vcount > 9'(MaxVertices)) ? CW'(MaxVertices) : CW'(vcount);
  assign in_ok = ({1'b0, in_beat.edge_u} < nact) && ({1'b0, in_beat.edge_v} < nact);
  assign scan_e = t_s[EW-1:0];

  always_comb begin
    hit = 1'b0;
    other = '0;
    if (erd[2*VW-1:VW] == t_v) begin
      hit = 1'b1;
      other = erd[VW-1:0];
    end else if (erd[VW-1:0] == t_v) begin
      hit = 1'b1;
      other = erd[2*VW-1:VW];
    end
    if (t_t && t_e == scan_e) hit = 1'b0;
  end

  assign stat.root_end    = root >= nact;
  assign stat.root_skip   = (root < nact) && visited[root[VW-1:0]];
  assign stat.scan_end    = t_s >= etotal;
  assign stat.found       = found;
  assign stat.stack_empty = sp == '0;
  assign res.has_cycle    = found;
  assign res.bad_edge     = bad;

  always_ff @(posedge clk) begin
    erd <= estore[scan_e];
    if (cmd.load && in_beat.edge_present && in_ok && etotal < (EW+1)'(MaxEdges))
      estore[etotal[EW-1:0]] <= {in_beat.edge_u, in_beat.edge_v};
  end

  // walk stack frame writes and current-frame register updates
  always_ff @(posedge clk) begin
    if (cmd.root) begin
      sv[0] <= root[VW-1:0];
      stt[0] <= 1'b0;
      ste[0] <= '0;
      sscn[0] <= '0;
      t_v <= root[VW-1:0];
      t_t <= 1'b0;
      t_e <= '0;
      t_s <= '0;
    end else if (cmd.eval) begin
      if (hit && !(visited[other]) && sp < CW'(MaxVertices)) begin
        sscn[sp[VW-1:0] - 1'b1] <= t_s + 1'b1;
        sv[sp[VW-1:0]] <= other;
        ste[sp[VW-1:0]] <= scan_e;
        stt[sp[VW-1:0]] <= 1'b1;
        t_v <= other;
        t_e <= scan_e;
        t_t <= 1'b1;
        t_s <= '0;
      end else begin
        t_s <= t_s + 1'b1;
      end
    end else if (cmd.pop && sp > CW'(1)) begin
      t_v <= sv[sp[VW-1:0] - 2'd2];
      t_e <= ste[sp[VW-1:0] - 2'd2];
      t_t <= stt[sp[VW-1:0] - 2'd2];
      t_s <= sscn[sp[VW-1:0] - 2'd2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= 9'd256;
      etotal <= '0;
      bad <= 1'b0;
      visited <= '0;
      sp <= '0;
      root <= '0;
      found <= 1'b0;
    end else begin
      if (cfg_we) vcount <= cfg_data;
      if (cmd.load && in_beat.edge_present) begin
        if (!in_ok) bad <= 1'b1;
        else if (etotal < (EW+1)'(MaxEdges)) etotal <= etotal + 1'b1;
      end
      if (cmd.clr) begin
        visited <= '0;
        root <= '0;
        found <= 1'b0;
        sp <= '0;
      end
      if (cmd.root) begin
        if (visited[root[VW-1:0]]) begin
          root <= root + 1'b1;
        end else begin
          visited[root[VW-1:0]] <= 1'b1;
          sp <= CW'(1);
          root <= root + 1'b1;
        end
      end
      if (cmd.eval && hit) begin
        if (visited[other] || sp >= CW'(MaxVertices)) begin
          found <= 1'b1;
          if (!visited[other]) visited[other] <= 1'b1;
        end else begin
          visited[other] <= 1'b1;
          sp <= sp + 1'b1;
        end
      end
      if (cmd.pop) sp <= sp - 1'b1;
      if (cmd.finish) begin
        etotal <= '0;
        bad <= 1'b0;
        visited <= '0;
      end
    end
  end

endmodule

// ===== design/ucd_ctrl.sv =====
// ucd_ctrl: sequencer for edge loading and depth-first walk
// depends on ucd_pkg
module ucd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           last_edge,
  input  ucd_pkg::stat_t stat,
  output ucd_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);
  import ucd_pkg::*;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    done = 1'b0;
    busy = state != S_LOAD;
    unique case (state)
      S_LOAD: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_edge) state_next = S_CLR;
        end
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        if (stat.root_end) state_next = S_DONE;
        else begin
          cmd.root = 1'b1;
          if (!stat.root_skip) state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (stat.found) state_next = S_DONE;
        else if (stat.stack_empty) state_next = S_ROOT;
        else if (stat.scan_end) state_next = S_POP;
        else state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: state_next = S_FETCH;
      S_POP: begin
        cmd.pop = 1'b1;
        state_next = S_WAIT;
      end
      S_DONE: begin
        done = 1'b1;
        cmd.finish = 1'b1;
        state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else state <= state_next;
  end

endmodule

// ===== design/undirected_cycle_detect.sv =====
// undirected_cycle_detect: top level joining controller and datapath
// depends on ucd_pkg, ucd_ctrl, ucd_datapath
//
//  channel  | handshake          | payload
//  in       | start, !busy       | in_beat (edge_u, edge_v, edge_present, last_edge)
//  out      | done (one cycle)   | result (has_cycle, bad_edge)
//  cfg      | cfg_we             | cfg_data (vertex_count)
//
// edge beats load one per cycle while busy is low; the last beat starts the walk
// walk: a clear state, then a root probe per root; each edge scan step passes through the
// fetch, eval and wait states (registered store read, then update) and each pop through
// the pop, wait and fetch states; a done state ends the walk and busy drops after it
// done is high for one cycle; the receiver cannot stall
// rst is synchronous and clears counters, flags and the visited map
module undirected_cycle_detect (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ucd_pkg::in_beat_t  in_beat,
  output logic               done,
  output ucd_pkg::out_beat_t result,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_data
);
  import ucd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ucd_ctrl u_ctrl (
    .clk, .rst, .start, .last_edge(in_beat.last_edge),
    .stat, .cmd, .busy, .done
  );

  ucd_datapath u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .in_beat, .cmd, .stat, .res(result)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after result");
  a_no_done_load: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !in_beat.last_edge) |=> !done) else $error("stray result");

endmodule

// ===== sim/undirected_cycle_detect_test.sv =====
// undirected_cycle_detect_test: self-checking bench for the cycle detector
// drives edge beats through start/busy, predicts each graph verdict, checks done beats
// depends on ucd_pkg and undirected_cycle_detect
module undirected_cycle_detect_test;
  import ucd_pkg::*;

  localparam int WatchdogLimit = 400000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_beat_t in_beat;
  logic done;
  out_beat_t result;
  logic cfg_we;
  logic [8:0] cfg_data;

  undirected_cycle_detect u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_beat(in_beat),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  in_beat_t edge_beats_q[$];
  out_beat_t verdict_q[$];

  logic [8:0] vertex_count;
  logic [7:0] store_u [MaxEdges];
  logic [7:0] store_v [MaxEdges];
  int edge_total;
  bit bad_seen;

  int mismatches;
  int beats_taken;
  int verdicts_seen;
  int cycles_found;
  int bad_reported;
  int settings_used;
  int idle_cycles;
  bit took_beat;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int active_count();
    return (vertex_count > MaxVertices) ? MaxVertices : int'(vertex_count);
  endfunction

  function automatic bit graph_has_cycle();
    bit seen [MaxVertices];
    int st_vtx [MaxVertices];
    int st_tree [MaxVertices];
    bit st_has [MaxVertices];
    int st_scan [MaxVertices];
    int n, sp, e, other, top;
    bit went_down;
    n = active_count();
    foreach (seen[i]) seen[i] = 1'b0;
    for (int s = 0; s < n; s++) begin
      if (seen[s]) continue;
      seen[s] = 1'b1;
      st_vtx[0] = s; st_has[0] = 1'b0; st_tree[0] = 0; st_scan[0] = 0;
      sp = 1;
      while (sp > 0) begin
        top = sp - 1;
        went_down = 1'b0;
        while (st_scan[top] < edge_total) begin
          e = st_scan[top];
          st_scan[top] = e + 1;
          if (store_u[e] == st_vtx[top]) other = store_v[e];
          else if (store_v[e] == st_vtx[top]) other = store_u[e];
          else continue;
          if (st_has[top] && st_tree[top] == e) continue;
          if (seen[other]) return 1'b1;
          seen[other] = 1'b1;
          if (sp >= MaxVertices) return 1'b1;
          st_vtx[sp] = other; st_tree[sp] = e; st_has[sp] = 1'b1; st_scan[sp] = 0;
          sp++;
          went_down = 1'b1;
          break;
        end
        if (!went_down) sp--;
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_beat(input in_beat_t b);
    out_beat_t r;
    int n;
    n = active_count();
    if (b.edge_present) begin
      if (b.edge_u >= n || b.edge_v >= n) bad_seen = 1'b1;
      else if (edge_total < MaxEdges) begin
        store_u[edge_total] = b.edge_u;
        store_v[edge_total] = b.edge_v;
        edge_total++;
      end
    end
    if (b.last_edge) begin
      r.has_cycle = graph_has_cycle();
      r.bad_edge = bad_seen;
      verdict_q.push_back(r);
      edge_total = 0;
      bad_seen = 1'b0;
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took_beat) begin
      if (edge_beats_q.size() > 0 &&
          ((beats_taken > 500 && beats_taken < 800) || $urandom_range(99) >= 7)) begin
        start <= 1'b1;
        in_beat <= edge_beats_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    took_beat <= !rst && start && !busy;
    if (!rst) begin
      if (done) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected done beat: %b", result);
        end else begin
          if (result.has_cycle !== verdict_q[0].has_cycle ||
              result.bad_edge !== verdict_q[0].bad_edge) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected cycle=%b bad=%b, got cycle=%b bad=%b",
                       verdict_q[0].has_cycle, verdict_q[0].bad_edge,
                       result.has_cycle, result.bad_edge);
          end
          if (verdict_q[0].has_cycle) cycles_found++;
          if (verdict_q[0].bad_edge) bad_reported++;
          void'(verdict_q.pop_front());
        end
      end
      if (start && !busy) begin
        beats_taken++;
        predict_beat(in_beat);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_beat(input int u, input int v, input bit p, input bit l);
    in_beat_t b;
    b.edge_u = u[7:0];
    b.edge_v = v[7:0];
    b.edge_present = p;
    b.last_edge = l;
    edge_beats_q.push_back(b);
  endtask

  task automatic random_graph(input int n);
    int k, mode, off, lim;
    lim = (n < 1) ? 1 : n;
    k = $urandom_range(0, 24);
    mode = $urandom_range(0, 9);
    off = $urandom_range(0, 255);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(99) < 5) push_beat($urandom, $urandom, 1'b0, 1'b0);
      if (mode < 5 && i + 1 < lim)
        push_beat((i + 1 + off) % lim, ($urandom_range(0, i) + off) % lim, 1'b1, 1'b0);
      else if (mode < 9)
        push_beat($urandom_range(0, lim - 1), $urandom_range(0, lim - 1), 1'b1, 1'b0);
      else
        push_beat($urandom_range(0, 255), $urandom_range(0, 255), 1'b1, 1'b0);
    end
    if ($urandom_range(1)) push_beat($urandom_range(0, lim - 1), $urandom_range(0, lim - 1),
                                     1'b1, 1'b1);
    else push_beat($urandom, $urandom, 1'b0, 1'b1);
  endtask

  task automatic drain_and_set(input logic [8:0] vc);
    wait (edge_beats_q.size() == 0 && verdict_q.size() == 0);
    @(negedge clk);
    while (start || busy) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= vc;
    vertex_count = vc;
    settings_used++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [8:0] settings [$];
    int phase_start;
    rst = 1'b1;
    start = 1'b0;
    in_beat = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    vertex_count = 9'd256;
    edge_total = 0;
    bad_seen = 1'b0;
    mismatches = 0;
    beats_taken = 0;
    verdicts_seen = 0;
    cycles_found = 0;
    bad_reported = 0;
    settings_used = 0;
    took_beat = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed graphs at reset vertex count
    push_beat(5, 5, 1'b1, 1'b1);
    push_beat(0, 1, 1'b1, 1'b0); push_beat(1, 0, 1'b1, 1'b1);
    push_beat(0, 1, 1'b1, 1'b0); push_beat(1, 2, 1'b1, 1'b0); push_beat(2, 0, 1'b1, 1'b1);
    push_beat(255, 0, 1'b1, 1'b0); push_beat(0, 128, 1'b1, 1'b0);
    push_beat(0, 0, 1'b0, 1'b0); push_beat(128, 77, 1'b1, 1'b1);
    push_beat(0, 0, 1'b0, 1'b1);
    push_beat(255, 255, 1'b0, 1'b1);
    drain_and_set(9'd4);
    push_beat(0, 4, 1'b1, 1'b0); push_beat(0, 1, 1'b1, 1'b1);
    push_beat(200, 1, 1'b1, 1'b0); push_beat(1, 2, 1'b1, 1'b0); push_beat(2, 1, 1'b1, 1'b1);
    drain_and_set(9'd0);
    push_beat(0, 0, 1'b1, 1'b1);
    drain_and_set(9'd511);
    push_beat(255, 254, 1'b1, 1'b0); push_beat(254, 255, 1'b1, 1'b1);
    drain_and_set(9'd2);
    // fill the edge store past its depth; extra beats are dropped silently
    for (int i = 0; i < MaxEdges + 4; i++) push_beat(0, 1, 1'b1, i == MaxEdges + 3);

    settings = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd257, 9'd2, 9'd16, 9'd255};
    for (int i = 0; i < 4; i++) settings.push_back(9'($urandom_range(1, 511)));
    foreach (settings[i]) begin
      drain_and_set(settings[i]);
      phase_start = beats_taken + edge_beats_q.size();
      while (edge_beats_q.size() + beats_taken - phase_start < 25)
        random_graph(active_count());
    end

    wait (edge_beats_q.size() == 0 && verdict_q.size() == 0);
    @(negedge clk);
    while (start || busy) @(negedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d edge beats and %0d graph verdicts over %0d vertex counts",
             beats_taken, verdicts_seen, settings_used);
    $display("graphs with a cycle: %0d, graphs with dropped edges: %0d",
             cycles_found, bad_reported);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
